// ----- rtl/wsdd_pkg.sv -----
// Shared types and constants for the waypoint steering block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package wsdd_pkg;

   // Default sizes of the angle and wheel speed fields.
   localparam int ANGLE_BITS_DEF = 16;
   localparam int SPEED_BITS_DEF = 16;

   // Fixed field widths.
   localparam int DIST_BITS  = 16;
   localparam int CFG_BITS   = 16;
   localparam int TRACK_BITS = 13;
   localparam int LIMIT_BITS = 14;
   localparam int MODE_BITS  = 3;

   // Quotient width of the shared divider; covers both the arc and pivot terms.
   localparam int QUOT_BITS = 29;

   // Quarter-wave sine polynomial coefficients, Q16.
   localparam logic [16:0] SIN_A = 17'd102944;
   localparam logic [15:0] SIN_B = 16'd42047;
   localparam logic [12:0] SIN_C = 13'd4640;
   localparam logic [16:0] SIN_ONE = 17'd65536;

   // Pivot rounding: round(pivot_rate * track / 2000).
   localparam logic [QUOT_BITS-1:0] PIVOT_ROUND = QUOT_BITS'(1000);
   localparam logic [DIST_BITS-1:0] PIVOT_DIV   = DIST_BITS'(2000);

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_FORWARD_SPEED  = 3'd0,
      REG_REVERSE_SPEED  = 3'd1,
      REG_PIVOT_RATE     = 3'd2,
      REG_TRACK_WIDTH    = 3'd3,
      REG_NO_TURN_LIMIT  = 3'd4,
      REG_ARC_TURN_LIMIT = 3'd5
   } reg_index_type;

   // Drive modes.
   typedef enum logic [MODE_BITS-1:0] {
      MODE_FWD_STRAIGHT = 3'd0,
      MODE_FWD_RIGHT    = 3'd1,
      MODE_PIVOT_RIGHT  = 3'd2,
      MODE_REV_RIGHT    = 3'd3,
      MODE_REV_STRAIGHT = 3'd4,
      MODE_REV_LEFT     = 3'd5,
      MODE_PIVOT_LEFT   = 3'd6,
      MODE_FWD_LEFT     = 3'd7
   } mode_type;

   // How the wheel speeds are formed from the quotient.
   typedef enum logic [1:0] {
      KIND_STRAIGHT = 2'd0,
      KIND_ARC      = 2'd1,
      KIND_PIVOT    = 2'd2
   } kind_type;

   // Configuration register set.
   typedef struct packed {
      logic signed [CFG_BITS-1:0]   forward_speed;
      logic signed [CFG_BITS-1:0]   reverse_speed;
      logic        [CFG_BITS-1:0]   pivot_rate;
      logic        [TRACK_BITS-1:0] track_mm;
      logic        [LIMIT_BITS-1:0] no_turn_limit;
      logic        [LIMIT_BITS-1:0] arc_turn_limit;
   } cfg_type;

   // Per-transaction control that rides along the pipeline.
   // sel set: right = speed - q, left = speed + q; clear: the other way round.
   typedef struct packed {
      mode_type                   mode;
      logic                       sel;
      logic signed [CFG_BITS-1:0] speed;
   } ctl_type;

endpackage

`default_nettype wire

// ----- rtl/wsdd_front.sv -----
// Front end: bearing, cone selection, sine polynomial and numerator products.
// Seven register stages; depends on wsdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsdd_front
   import wsdd_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        en,
   input  wire cfg_type               cfg,
   input  wire                        in_valid,
   input  wire [ANGLE_BITS-1:0]       in_heading,
   input  wire [ANGLE_BITS-1:0]       in_yaw,
   input  wire [DIST_BITS-1:0]        in_dist,
   output logic                       out_valid,
   output ctl_type                    out_ctl,
   output logic [QUOT_BITS-1:0]       out_num,
   output logic [DIST_BITS-1:0]       out_den
);

   localparam int CW = ((ANGLE_BITS > LIMIT_BITS) ? ANGLE_BITS : LIMIT_BITS) + 2;
   localparam logic signed [CW-1:0] TURN = CW'(64'd1 << ANGLE_BITS);
   localparam logic signed [CW-1:0] HALF = CW'(64'd1 << (ANGLE_BITS - 1));
   localparam logic [ANGLE_BITS-2:0] HALF_U = (ANGLE_BITS-1)'(64'd1 << (ANGLE_BITS - 1));
   localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(64'd1 << (ANGLE_BITS - 2));

   // Stage valid bits.
   logic [6:0] v_ff;

   // Stage 1 results.
   ctl_type                 ctl1_in, ctl1_ff;
   kind_type                kind1_in, kind1_ff;
   logic [16:0]             x1_in, x1_ff;
   logic [15:0]             mag1_in, mag1_ff;
   logic [DIST_BITS-1:0]    d1_ff;

   // Later stages.
   ctl_type                 ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff;
   kind_type                kind2_ff, kind3_ff, kind4_ff, kind5_ff, kind6_ff;
   logic [DIST_BITS-1:0]    d2_ff, d3_ff, d4_ff, d5_ff, d6_ff;
   logic [16:0]             x2_ff, x3_ff, x4_ff;
   logic [16:0]             sq2_in, sq2_ff, sq3_ff;
   logic [28:0]             mt2_ff, mt3_ff, mt4_ff, mt5_ff;
   logic [15:0]             t3_in, t3_ff;
   logic [16:0]             t4_in, t4_ff;
   logic [16:0]             s5_in, s5_ff;
   logic [45:0]             num6_ff;
   logic [QUOT_BITS-1:0]    piv_ff;
   logic [QUOT_BITS-1:0]    n7_in, n7_ff;
   logic [DIST_BITS-1:0]    den7_in, den7_ff;
   ctl_type                 ctl7_ff;

   // Bearing, cone selection and folded angle.
   always_comb begin
      logic [ANGLE_BITS-1:0]  b;
      logic signed [CW-1:0]   bs, n, a;
      logic [ANGLE_BITS-2:0]  u;
      logic [ANGLE_BITS+15:0] ux;
      logic signed [16:0]     sp;
      b  = in_heading + in_yaw;
      bs = CW'(b);
      n  = CW'(cfg.no_turn_limit);
      a  = CW'(cfg.arc_turn_limit);
      ctl1_in.speed = cfg.forward_speed;
      ctl1_in.sel   = 1'b0;
      kind1_in      = KIND_STRAIGHT;
      if (bs <= n || bs >= TURN - n) begin
         ctl1_in.mode = MODE_FWD_STRAIGHT;
      end else if (bs <= a) begin
         ctl1_in.mode = MODE_FWD_RIGHT;
         kind1_in     = KIND_ARC;
      end else if (bs <= HALF - a) begin
         ctl1_in.mode = MODE_PIVOT_RIGHT;
         kind1_in     = KIND_PIVOT;
      end else if (bs <= HALF - n) begin
         ctl1_in.mode  = MODE_REV_RIGHT;
         ctl1_in.speed = cfg.reverse_speed;
         kind1_in      = KIND_ARC;
      end else if (bs <= HALF + n) begin
         ctl1_in.mode  = MODE_REV_STRAIGHT;
         ctl1_in.speed = cfg.reverse_speed;
      end else if (bs <= HALF + a) begin
         ctl1_in.mode  = MODE_REV_LEFT;
         ctl1_in.speed = cfg.reverse_speed;
         kind1_in      = KIND_ARC;
      end else if (bs <= TURN - a) begin
         ctl1_in.mode = MODE_PIVOT_LEFT;
         kind1_in     = KIND_PIVOT;
      end else begin
         ctl1_in.mode = MODE_FWD_LEFT;
         kind1_in     = KIND_ARC;
      end
      // Pivots carry no base speed; the right-hand pivot subtracts on the right.
      if (kind1_in == KIND_PIVOT) begin
         ctl1_in.speed = '0;
         ctl1_in.sel   = (ctl1_in.mode == MODE_PIVOT_RIGHT);
      end else if (kind1_in == KIND_ARC) begin
         ctl1_in.sel = ctl1_in.speed[CFG_BITS-1] ^ (bs > HALF);
      end
      sp      = 17'(ctl1_in.speed);
      mag1_in = sp[16] ? 16'(-sp) : 16'(sp);
      u = b[ANGLE_BITS-2:0];
      if (u > QUARTER) begin
         u = HALF_U - u;
      end
      ux    = {1'b0, u, 16'b0} >> (ANGLE_BITS - 2);
      x1_in = ux[16:0];
   end

   // Polynomial steps; each stage holds one multiply.
   always_comb begin
      logic [33:0] p2;
      logic [29:0] p3;
      logic [32:0] p4;
      logic [33:0] p5;
      p2     = 34'(x1_ff) * 34'(x1_ff);
      sq2_in = p2[32:16];
      p3     = 30'(SIN_C) * 30'(sq2_ff);
      t3_in  = SIN_B - 16'(p3[29:16]);
      p4     = 33'(t3_ff) * 33'(sq3_ff);
      t4_in  = SIN_A - p4[32:16];
      p5     = 34'(t4_ff) * 34'(x4_ff);
      s5_in  = (p5[33:16] > 18'(SIN_ONE)) ? SIN_ONE : p5[32:16];
   end

   // Divider operands: the arc term rounds by half the denominator first.
   always_comb begin
      logic [46:0] sum;
      sum     = 47'(num6_ff) + (47'(d6_ff) << 15);
      n7_in   = '0;
      den7_in = DIST_BITS'(1);
      if (kind6_ff == KIND_ARC && d6_ff != '0) begin
         n7_in   = sum[16 +: QUOT_BITS];
         den7_in = d6_ff;
      end else if (kind6_ff == KIND_PIVOT) begin
         n7_in   = piv_ff;
         den7_in = PIVOT_DIV;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   // Pivot numerator follows the configuration.
   always_ff @(posedge clock) begin
      piv_ff <= QUOT_BITS'(cfg.pivot_rate) * QUOT_BITS'(cfg.track_mm) + PIVOT_ROUND;
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (en) begin
         ctl1_ff <= ctl1_in;  kind1_ff <= kind1_in; x1_ff <= x1_in;
         mag1_ff <= mag1_in;  d1_ff <= in_dist;
         ctl2_ff <= ctl1_ff;  kind2_ff <= kind1_ff; d2_ff <= d1_ff; x2_ff <= x1_ff;
         sq2_ff  <= sq2_in;
         mt2_ff  <= 29'(mag1_ff) * 29'(cfg.track_mm);
         ctl3_ff <= ctl2_ff;  kind3_ff <= kind2_ff; d3_ff <= d2_ff; x3_ff <= x2_ff;
         sq3_ff  <= sq2_ff;   mt3_ff <= mt2_ff;     t3_ff <= t3_in;
         ctl4_ff <= ctl3_ff;  kind4_ff <= kind3_ff; d4_ff <= d3_ff; x4_ff <= x3_ff;
         mt4_ff  <= mt3_ff;   t4_ff <= t4_in;
         ctl5_ff <= ctl4_ff;  kind5_ff <= kind4_ff; d5_ff <= d4_ff;
         mt5_ff  <= mt4_ff;   s5_ff <= s5_in;
         ctl6_ff <= ctl5_ff;  kind6_ff <= kind5_ff; d6_ff <= d5_ff;
         num6_ff <= 46'(mt5_ff) * 46'(s5_ff);
         ctl7_ff <= ctl6_ff;  n7_ff <= n7_in;       den7_ff <= den7_in;
      end
   end

   assign out_valid = v_ff[6];
   assign out_ctl   = ctl7_ff;
   assign out_num   = n7_ff;
   assign out_den   = den7_ff;

endmodule

`default_nettype wire

// ----- rtl/wsdd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, control rides along.
// Depends on wsdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsdd_div
   import wsdd_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  wire                     in_valid,
   input  wire ctl_type            in_ctl,
   input  wire [QUOT_BITS-1:0]     in_num,
   input  wire [DIST_BITS-1:0]     in_den,
   output logic                    out_valid,
   output ctl_type                 out_ctl,
   output logic [QUOT_BITS-1:0]    out_quot
);

   logic                   v_ff   [QUOT_BITS];
   ctl_type                ctl_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0]   n_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0]   q_ff   [QUOT_BITS];
   logic [DIST_BITS-1:0]   rem_ff [QUOT_BITS];
   logic [DIST_BITS-1:0]   den_ff [QUOT_BITS];

   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_stage
      logic                 v_src;
      ctl_type              ctl_src;
      logic [QUOT_BITS-1:0] n_src, q_src;
      logic [DIST_BITS-1:0] rem_src, den_src;
      logic [DIST_BITS:0]   trial;
      logic                 ge;

      if (i == 0) begin : g_first
         assign v_src   = in_valid;
         assign ctl_src = in_ctl;
         assign n_src   = in_num;
         assign q_src   = '0;
         assign rem_src = '0;
         assign den_src = in_den;
      end else begin : g_next
         assign v_src   = v_ff[i-1];
         assign ctl_src = ctl_ff[i-1];
         assign n_src   = n_ff[i-1];
         assign q_src   = q_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
      end

      // Shift in the next numerator bit and try a subtraction.
      assign trial = {rem_src, n_src[QUOT_BITS-1]};
      assign ge    = (trial >= {1'b0, den_src});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff[i] <= ctl_src;
            n_ff[i]   <= n_src << 1;
            q_ff[i]   <= {q_src[QUOT_BITS-2:0], ge};
            rem_ff[i] <= ge ? DIST_BITS'(trial - {1'b0, den_src}) : trial[DIST_BITS-1:0];
            den_ff[i] <= den_src;
         end
      end
   end

   assign out_valid = v_ff[QUOT_BITS-1];
   assign out_ctl   = ctl_ff[QUOT_BITS-1];
   assign out_quot  = q_ff[QUOT_BITS-1];

endmodule

`default_nettype wire

// ----- rtl/waypoint_steering_diff_drive_top.sv -----
// Top level of the waypoint steering block: registers, pipeline and output stage.
// Depends on wsdd_pkg, wsdd_front and wsdd_div.
//
// Usage: each req transaction carries a waypoint heading, a vehicle yaw and a
// distance; each one yields exactly one rsp transaction with the drive mode and
// the saturated right and left wheel speeds, in the order of the requests.
// Configuration registers are written through the csr port (index, data,
// write enable); the user must write them only while no request is in flight;
// the block does not enforce this. A request passes the 7 front-end stages,
// one stage per quotient bit in the 29-stage divider and the output register;
// the divider pipeline sets the depth. One transaction per cycle unless stalled.
// The whole pipeline advances together: when the receiver holds rsp_tready low
// with a response waiting, every stage holds and req_tready drops, so nothing
// is lost or repeated.
// Synchronous reset empties the pipeline and loads the default register
// values (forward 1200, reverse -500, pivot 175, track 500, limits 910/5461).
`timescale 1ns / 1ps
`default_nettype none

module waypoint_steering_diff_drive_top
   import wsdd_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int SPEED_BITS = SPEED_BITS_DEF,
   localparam int REQ_BITS = ((2 * ANGLE_BITS + DIST_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((MODE_BITS + 2 * SPEED_BITS + 7) / 8) * 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   // target_heading, vehicle_yaw, target_distance (lowest bits first)
   input  wire [REQ_BITS-1:0]   req_tdata,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   // drive_mode, right_speed, left_speed (lowest bits first)
   output logic [RSP_BITS-1:0]  rsp_tdata,
   input  wire                  csr_we,
   input  wire [2:0]            csr_index,
   input  wire [CFG_BITS-1:0]   csr_wdata
);

   localparam int SUM_BITS = QUOT_BITS + 2;
   localparam logic signed [SUM_BITS-1:0] SPD_MAX = SUM_BITS'((64'd1 << (SPEED_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] SPD_MIN = -SPD_MAX - SUM_BITS'(1);

   cfg_type                 cfg_ff;
   logic                    en;
   logic                    fr_valid, dv_valid;
   ctl_type                 fr_ctl, dv_ctl;
   logic [QUOT_BITS-1:0]    fr_num, dv_quot;
   logic [DIST_BITS-1:0]    fr_den;
   logic                    rsp_valid_ff;
   logic [MODE_BITS-1:0]    mode_in, mode_ff;
   logic signed [SPEED_BITS-1:0] right_in, right_ff, left_in, left_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forward_speed  <= CFG_BITS'(1200);
         cfg_ff.reverse_speed  <= -CFG_BITS'(500);
         cfg_ff.pivot_rate     <= CFG_BITS'(175);
         cfg_ff.track_mm       <= TRACK_BITS'(500);
         cfg_ff.no_turn_limit  <= LIMIT_BITS'(910);
         cfg_ff.arc_turn_limit <= LIMIT_BITS'(5461);
      end else if (csr_we) begin
         case (csr_index)
            REG_FORWARD_SPEED:  cfg_ff.forward_speed  <= csr_wdata;
            REG_REVERSE_SPEED:  cfg_ff.reverse_speed  <= csr_wdata;
            REG_PIVOT_RATE:     cfg_ff.pivot_rate     <= csr_wdata;
            REG_TRACK_WIDTH:    cfg_ff.track_mm       <= csr_wdata[TRACK_BITS-1:0];
            REG_NO_TURN_LIMIT:  cfg_ff.no_turn_limit  <= csr_wdata[LIMIT_BITS-1:0];
            REG_ARC_TURN_LIMIT: cfg_ff.arc_turn_limit <= csr_wdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or being drained.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   wsdd_front #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_heading (req_tdata[ANGLE_BITS-1:0]),
      .in_yaw     (req_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
      .in_dist    (req_tdata[2*ANGLE_BITS +: DIST_BITS]),
      .out_valid  (fr_valid),
      .out_ctl    (fr_ctl),
      .out_num    (fr_num),
      .out_den    (fr_den)
   );

   wsdd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_ctl    (fr_ctl),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .out_valid (dv_valid),
      .out_ctl   (dv_ctl),
      .out_quot  (dv_quot)
   );

   // Wheel speeds from base speed and quotient, then saturation.
   always_comb begin
      logic signed [SUM_BITS-1:0] spd, q, r, l;
      spd = SUM_BITS'(dv_ctl.speed);
      q   = SUM_BITS'(dv_quot);
      r   = dv_ctl.sel ? spd - q : spd + q;
      l   = dv_ctl.sel ? spd + q : spd - q;
      mode_in  = dv_ctl.mode;
      right_in = (r > SPD_MAX) ? SPEED_BITS'(SPD_MAX) :
                 (r < SPD_MIN) ? SPEED_BITS'(SPD_MIN) : SPEED_BITS'(r);
      left_in  = (l > SPD_MAX) ? SPEED_BITS'(SPD_MAX) :
                 (l < SPD_MIN) ? SPEED_BITS'(SPD_MIN) : SPEED_BITS'(l);
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff  <= mode_in;
         right_ff <= right_in;
         left_ff  <= left_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({left_ff, right_ff, mode_ff});

`ifndef ASSERT_OFF
   // Straight modes drive both wheels alike.
   a_straight_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (mode_ff == MODE_FWD_STRAIGHT || mode_ff == MODE_REV_STRAIGHT)
      |-> right_ff == left_ff)
      else $error("straight mode with unequal wheel speeds");

   // A right pivot never drives the right wheel forward.
   a_pivot_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && mode_ff == MODE_PIVOT_RIGHT |-> right_ff <= 0 && left_ff >= 0)
      else $error("right pivot with wrong wheel signs");

   // A left pivot never drives the left wheel forward.
   a_pivot_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && mode_ff == MODE_PIVOT_LEFT |-> left_ff <= 0 && right_ff >= 0)
      else $error("left pivot with wrong wheel signs");

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the waypoint steering block.
// Depends on wsdd_pkg and waypoint_steering_diff_drive_top;
// drives random and directed steering requests.
`timescale 1ns / 1ps

module tb;
   import wsdd_pkg::*;

   localparam int LATENCY = 37;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [47:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   waypoint_steering_diff_drive_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] right;
      logic signed [15:0] left;
   } wheel_cmd_type;

   // Predictor copy of the registers.
   logic signed [15:0] fwd_spd, rev_spd;
   logic [15:0]        piv_rate;
   logic [12:0]        track;
   logic [13:0]        lim_straight, lim_arc;

   logic [47:0]   pending_reqs[$];
   wheel_cmd_type expected_cmds[$];
   int            error_count = 0;
   int            send_idle_pct = 0, recv_idle_pct = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #100ms;
      $display("tb: errors");
      $finish;
   end

   task automatic report(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic logic [15:0] sat_speed(input longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // Quarter-wave polynomial |sin| in Q16.
   function automatic longint abs_sin(input logic [15:0] b);
      longint u, x, x2, t;
      u = b & 16'h7fff;
      if (u > 16384) u = 32768 - u;
      x = (u << 16) >> 14;
      x2 = (x * x) >> 16;
      t = 42047 - ((4640 * x2) >> 16);
      t = 102944 - ((t * x2) >> 16);
      t = (t * x) >> 16;
      if (t > 65536) t = 65536;
      return t;
   endfunction

   function automatic wheel_cmd_type steer(input logic [47:0] item);
      logic [15:0] bu;
      longint b, d, n, a, diff, spd, r, l, mag, num, den, delta;
      logic [2:0] m;
      bit arc;
      wheel_cmd_type c;
      bu = item[15:0] + item[31:16];
      b = bu; d = item[47:32]; n = lim_straight; a = lim_arc;
      diff = (longint'(piv_rate) * longint'(track) + 1000) / 2000;
      arc = 0; spd = 0; r = 0; l = 0;
      if (b <= n || b >= 65536 - n) begin m = MODE_FWD_STRAIGHT; r = fwd_spd; l = fwd_spd; end
      else if (b <= a) begin m = MODE_FWD_RIGHT; spd = fwd_spd; arc = 1; end
      else if (b <= 32768 - a) begin m = MODE_PIVOT_RIGHT; r = -diff; l = diff; end
      else if (b <= 32768 - n) begin m = MODE_REV_RIGHT; spd = rev_spd; arc = 1; end
      else if (b <= 32768 + n) begin m = MODE_REV_STRAIGHT; r = rev_spd; l = rev_spd; end
      else if (b <= 32768 + a) begin m = MODE_REV_LEFT; spd = rev_spd; arc = 1; end
      else if (b <= 65536 - a) begin m = MODE_PIVOT_LEFT; r = diff; l = -diff; end
      else begin m = MODE_FWD_LEFT; spd = fwd_spd; arc = 1; end
      if (arc) begin
         if (d == 0) begin
            r = spd; l = spd;
         end else begin
            mag = spd < 0 ? -spd : spd;
            num = mag * longint'(track) * abs_sin(bu);
            den = d << 16;
            delta = (num + den / 2) / den;
            if (spd < 0) delta = -delta;
            if (b <= 32768) begin r = spd + delta; l = spd - delta; end
            else begin r = spd - delta; l = spd + delta; end
         end
      end
      c.mode = m; c.right = sat_speed(r); c.left = sat_speed(l);
      return c;
   endfunction

   // Driver: presents queued requests; a new item is predicted on acceptance.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_cmds = {expected_cmds, steer(req_tdata)};
            void'(pending_reqs.pop_front());
         end
         if ((!req_tvalid || req_tready) &&
             !(pending_reqs.size() > (req_tvalid && req_tready ? 0 : 0) &&
               $urandom_range(99) >= 100 - send_idle_pct)) begin
            if (pending_reqs.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_reqs[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (req_tvalid && req_tready) begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: compares each accepted response with the oldest prediction.
   always @(posedge clock) begin
      wheel_cmd_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mode = rsp_tdata[2:0];
         got.right = rsp_tdata[18:3];
         got.left = rsp_tdata[34:19];
         if (expected_cmds.size() == 0) begin
            report("response with nothing expected");
         end else begin
            want = expected_cmds.pop_front();
            if (got.mode != want.mode)
               report($sformatf("mode %0d want %0d", got.mode, want.mode));
            if (got.right != want.right)
               report($sformatf("right %0d want %0d", got.right, want.right));
            if (got.left != want.left)
               report($sformatf("left %0d want %0d", got.left, want.left));
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      case (idx)
         REG_FORWARD_SPEED:  fwd_spd = val;
         REG_REVERSE_SPEED:  rev_spd = val;
         REG_PIVOT_RATE:     piv_rate = val;
         REG_TRACK_WIDTH:    track = val[12:0];
         REG_NO_TURN_LIMIT:  lim_straight = val[13:0];
         REG_ARC_TURN_LIMIT: lim_arc = val[13:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Appends one request to the driver's queue.
   task automatic queue_req(input logic [47:0] r);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_cmds.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [47:0] pack_req(input logic [15:0] h, input logic [15:0] y,
                                            input logic [15:0] d);
      return {d, y, h};
   endfunction

   // A random request, biased toward short distances and cone boundaries.
   function automatic logic [47:0] rand_req();
      logic [15:0] h, y, d, b;
      h = 16'($urandom);
      case ($urandom_range(3))
         0: b = 16'($urandom);
         1: b = 16'(lim_straight + $urandom_range(2) - 1);
         2: b = 16'(32768 - lim_arc + $urandom_range(2) - 1);
         default: b = 16'(65536 - lim_arc + $urandom_range(2) - 1);
      endcase
      y = b - h;
      d = $urandom_range(1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
      return pack_req(h, y, d);
   endfunction

   initial begin
      int phase;
      fwd_spd = 1200; rev_spd = -500; piv_rate = 175; track = 500;
      lim_straight = 910; lim_arc = 5461;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed items with reset settings.
      send_idle_pct = 13; recv_idle_pct = 84;
      queue_req(pack_req(0, 0, 0));
      queue_req(pack_req(16'hffff, 16'hffff, 16'hffff));
      queue_req(pack_req(910, 0, 100));
      queue_req(pack_req(911, 0, 100));
      queue_req(pack_req(3000, 0, 0));
      queue_req(pack_req(16384, 0, 1000));
      queue_req(pack_req(32768, 0, 5));
      queue_req(pack_req(32768 - 3000, 0, 1));
      queue_req(pack_req(32768 + 3000, 0, 1));
      queue_req(pack_req(49152, 0, 50));
      queue_req(pack_req(65536 - 3000, 0, 1));
      queue_req(pack_req(65536 - 910, 0, 7));
      queue_req(pack_req(16'h8000, 16'h8000, 9));
      drain();

      // Several register settings, the extremes among them.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_FORWARD_SPEED, 16'h7fff); write_reg(REG_REVERSE_SPEED, 16'h8000);
               write_reg(REG_PIVOT_RATE, 16'hffff); write_reg(REG_TRACK_WIDTH, 16'h1fff);
               write_reg(REG_NO_TURN_LIMIT, 16'h3fff); write_reg(REG_ARC_TURN_LIMIT, 16'h3fff);
            end
            1: begin
               write_reg(REG_FORWARD_SPEED, 0); write_reg(REG_REVERSE_SPEED, 0);
               write_reg(REG_PIVOT_RATE, 0); write_reg(REG_TRACK_WIDTH, 0);
               write_reg(REG_NO_TURN_LIMIT, 0); write_reg(REG_ARC_TURN_LIMIT, 0);
            end
            2: begin
               // Limits out of order.
               write_reg(REG_FORWARD_SPEED, 16'h8000); write_reg(REG_REVERSE_SPEED, 16'h7fff);
               write_reg(REG_NO_TURN_LIMIT, 6000); write_reg(REG_ARC_TURN_LIMIT, 2000);
               write_reg(REG_TRACK_WIDTH, 8191); write_reg(REG_PIVOT_RATE, 40000);
            end
            default: begin
               write_reg(REG_FORWARD_SPEED, 16'($urandom));
               write_reg(REG_REVERSE_SPEED, 16'($urandom));
               write_reg(REG_PIVOT_RATE, 16'($urandom));
               write_reg(REG_TRACK_WIDTH, 16'($urandom));
               write_reg(REG_NO_TURN_LIMIT, 16'($urandom_range(0, 4000)));
               write_reg(REG_ARC_TURN_LIMIT, 16'($urandom_range(4000, 16383)));
            end
         endcase
         if (phase == 2) begin
            send_idle_pct = 84; recv_idle_pct = 13;
         end else if (phase == 4) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         repeat (200) queue_req(rand_req());
         drain();
      end

      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
